[rtl/ffha_pkg.sv]
// Shared constants, types and codes of the first-fit heap allocator.
// Used by ffha_alu, ffha_seq and the top level; depends on nothing else.
package ffha_pkg;

	localparam int HEAP_FRAMES   = 64;
	localparam int FRAME_BYTES   = 4096;
	localparam int GRAN_BYTES    = 16;
	localparam int HDR_BYTES     = 32;
	localparam int SPLIT_BYTES   = 32;
	localparam int HEAP_GRANULES = HEAP_FRAMES * (FRAME_BYTES / GRAN_BYTES);
	localparam int HDR_GRANS     = HDR_BYTES / GRAN_BYTES;
	localparam int SPLIT_GRANS   = SPLIT_BYTES / GRAN_BYTES;
	localparam int GRAN_SHIFT    = $clog2(GRAN_BYTES);

	// Granule index width and datapath width of the shared adder.
	localparam int GW      = $clog2(HEAP_GRANULES);
	localparam int BYTES_W = 20;
	localparam int OFF_W   = 18;
	localparam int NEED_W  = BYTES_W - GRAN_SHIFT + 1;
	localparam int AW      = ((GW + 1 > NEED_W) ? GW + 1 : NEED_W) + 1;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam int ALU_OP_W = 2;
	localparam logic [ALU_OP_W-1:0] ALU_ADD  = 2'd0;
	localparam logic [ALU_OP_W-1:0] ALU_SUB  = 2'd1;
	localparam logic [ALU_OP_W-1:0] ALU_ADDH = 2'd2;

	typedef struct packed {
		logic          valid;
		logic          free;
		logic [GW-1:0] prev;
		logic [GW-1:0] size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef struct packed {
		logic [ALU_OP_W-1:0] op;
		logic [AW-1:0]       a;
		logic [AW-1:0]       b;
	} alu_req_t;

	typedef struct packed {
		logic [AW-1:0] res;
		logic          geq;
	} alu_rsp_t;

	typedef struct packed {
		logic          we;
		logic [GW-1:0] waddr;
		hdr_t          wdata;
		logic          re;
		logic [GW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic               action;
		logic [BYTES_W-1:0] bytes;
		logic [OFF_W-1:0]   off;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0]    offset;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

[rtl/ffha_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the block header store of the allocator.
module ffha_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 16384,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/ffha_alu.sv]
// Shared add/subtract/compare unit of the allocator sequencer.
// Depends on ffha_pkg for widths and operation codes.
module ffha_alu
	import ffha_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [AW:0] b_eff;
	logic [AW:0] k;
	logic [AW:0] sum;

	always_comb begin
		case (req.op)
			ALU_SUB: begin
				b_eff = {1'b0, ~req.b};
				k     = (AW+1)'(1);
			end
			ALU_ADDH: begin
				b_eff = {1'b0, req.b};
				k     = (AW+1)'(HDR_GRANS);
			end
			default: begin
				b_eff = {1'b0, req.b};
				k     = '0;
			end
		endcase
		// For a subtraction the carry out is set exactly when a >= b.
		sum     = {1'b0, req.a} + b_eff + k;
		rsp.res = sum[AW-1:0];
		rsp.geq = sum[AW];
	end

endmodule

[rtl/ffha_seq.sv]
// Sequencer of the allocator: walks and updates the header store, reading
// one header at a time, around the shared ffha_alu. Depends on ffha_pkg.
module ffha_seq
	import ffha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  req_t     req,
	output logic     idle,
	input  logic     out_free,
	output logic     done,
	output res_t     res,
	output mem_req_t mem,
	input  hdr_t     rdata
);

	localparam int SW = 5;
	localparam logic [SW-1:0] S_INIT   = 5'd0;
	localparam logic [SW-1:0] S_IDLE   = 5'd1;
	localparam logic [SW-1:0] S_A_NEED = 5'd2;
	localparam logic [SW-1:0] S_A_CHK  = 5'd3;
	localparam logic [SW-1:0] S_A_NXT  = 5'd4;
	localparam logic [SW-1:0] S_A_SPL  = 5'd5;
	localparam logic [SW-1:0] S_A_T    = 5'd6;
	localparam logic [SW-1:0] S_A_TS   = 5'd7;
	localparam logic [SW-1:0] S_A_NX   = 5'd8;
	localparam logic [SW-1:0] S_A_NXW  = 5'd9;
	localparam logic [SW-1:0] S_A_HW   = 5'd10;
	localparam logic [SW-1:0] S_F_IDX  = 5'd11;
	localparam logic [SW-1:0] S_F_CHK  = 5'd12;
	localparam logic [SW-1:0] S_F_NX   = 5'd13;
	localparam logic [SW-1:0] S_F_NXC  = 5'd14;
	localparam logic [SW-1:0] S_F_NN   = 5'd15;
	localparam logic [SW-1:0] S_F_NNW  = 5'd16;
	localparam logic [SW-1:0] S_F_PV   = 5'd17;
	localparam logic [SW-1:0] S_F_PC   = 5'd18;
	localparam logic [SW-1:0] S_F_PN   = 5'd19;
	localparam logic [SW-1:0] S_F_PNW  = 5'd20;
	localparam logic [SW-1:0] S_F_GW   = 5'd21;
	localparam logic [SW-1:0] S_DONE   = 5'd22;

	localparam logic [AW-1:0] HEAP_END  = AW'(HEAP_GRANULES);
	localparam logic [AW-1:0] SPLIT_MIN = AW'(HDR_GRANS + SPLIT_GRANS);
	localparam logic [AW-1:0] HDR_AW    = AW'(HDR_GRANS);
	localparam logic [GW-1:0] INIT_SIZE = GW'(HEAP_GRANULES - HDR_GRANS);

	logic [SW-1:0] state_q, state_d;
	req_t          req_q, req_d;
	logic [GW-1:0] g_q, g_d;
	logic [AW-1:0] need_q, need_d;
	logic [AW-1:0] rem_q, rem_d;
	hdr_t          hdr_q, hdr_d;
	logic [GW-1:0] t_q, t_d;
	logic [GW-1:0] nx_q, nx_d;
	logic [GW-1:0] tmp_q, tmp_d;
	res_t          res_q, res_d;

	alu_req_t       alu_req;
	alu_rsp_t       alu_rsp;
	logic [AW+GRAN_SHIFT-1:0] off_wide;
	logic           in_heap;

	ffha_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign in_heap  = alu_rsp.res < HEAP_END;
	assign off_wide = {alu_rsp.res, {GRAN_SHIFT{1'b0}}};

	always_comb begin
		state_d = state_q;
		req_d   = req_q;
		g_d     = g_q;
		need_d  = need_q;
		rem_d   = rem_q;
		hdr_d   = hdr_q;
		t_d     = t_q;
		nx_d    = nx_q;
		tmp_d   = tmp_q;
		res_d   = res_q;
		alu_req = '{op: ALU_ADD, a: '0, b: '0};
		mem     = '0;
		idle    = 1'b0;
		done    = 1'b0;

		case (state_q)
			S_INIT: begin
				// Entry 0 becomes one free block spanning the whole heap.
				mem.we    = 1'b1;
				mem.waddr = '0;
				mem.wdata = '{valid: 1'b1, free: 1'b1, prev: '0, size: INIT_SIZE};
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					req_d = req;
					res_d = '{offset: '0, status: ST_OK};
					if (req.action == ACT_FREE) begin
						if (req.off < OFF_W'(HDR_BYTES) ||
								req.off[GRAN_SHIFT-1:0] != '0) begin
							state_d = S_DONE;
						end else begin
							state_d = S_F_IDX;
						end
					end else if (req.bytes == '0) begin
						res_d.status = ST_ZERO;
						state_d      = S_DONE;
					end else begin
						state_d = S_A_NEED;
					end
				end
			end

			// Allocation.
			S_A_NEED: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = AW'(req_q.bytes[BYTES_W-1:GRAN_SHIFT]);
				alu_req.b  = AW'(|req_q.bytes[GRAN_SHIFT-1:0]);
				need_d     = alu_rsp.res;
				g_d        = '0;
				mem.re     = 1'b1;
				mem.raddr  = '0;
				state_d    = S_A_CHK;
			end
			S_A_CHK: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = AW'(rdata.size);
				alu_req.b  = need_q;
				hdr_d      = rdata;
				rem_d      = alu_rsp.res;
				if (!rdata.valid) begin
					res_d.status = ST_EXHAUSTED;
					state_d      = S_DONE;
				end else if (rdata.free && alu_rsp.geq) begin
					state_d = S_A_SPL;
				end else begin
					state_d = S_A_NXT;
				end
			end
			S_A_NXT: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(g_q);
				alu_req.b  = AW'(hdr_q.size);
				if (in_heap) begin
					g_d       = alu_rsp.res[GW-1:0];
					mem.re    = 1'b1;
					mem.raddr = alu_rsp.res[GW-1:0];
					state_d   = S_A_CHK;
				end else begin
					res_d.status = ST_EXHAUSTED;
					state_d      = S_DONE;
				end
			end
			S_A_SPL: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = rem_q;
				alu_req.b  = SPLIT_MIN;
				state_d    = alu_rsp.geq ? S_A_T : S_A_HW;
			end
			S_A_T: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(g_q);
				alu_req.b  = need_q;
				t_d        = alu_rsp.res[GW-1:0];
				state_d    = S_A_TS;
			end
			S_A_TS: begin
				// The tail keeps what is left after the new header.
				alu_req.op = ALU_SUB;
				alu_req.a  = rem_q;
				alu_req.b  = HDR_AW;
				mem.we     = 1'b1;
				mem.waddr  = t_q;
				mem.wdata  = '{valid: 1'b1, free: 1'b1, prev: g_q,
					size: alu_rsp.res[GW-1:0]};
				state_d    = S_A_NX;
			end
			S_A_NX: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(g_q);
				alu_req.b  = AW'(hdr_q.size);
				hdr_d.size = need_q[GW-1:0];
				if (in_heap) begin
					nx_d      = alu_rsp.res[GW-1:0];
					mem.re    = 1'b1;
					mem.raddr = alu_rsp.res[GW-1:0];
					state_d   = S_A_NXW;
				end else begin
					state_d = S_A_HW;
				end
			end
			S_A_NXW: begin
				mem.we     = 1'b1;
				mem.waddr  = nx_q;
				mem.wdata  = rdata;
				mem.wdata.prev = t_q;
				state_d    = S_A_HW;
			end
			S_A_HW: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(g_q);
				alu_req.b  = '0;
				mem.we     = 1'b1;
				mem.waddr  = g_q;
				mem.wdata  = '{valid: 1'b1, free: 1'b0, prev: hdr_q.prev,
					size: hdr_q.size};
				res_d      = '{offset: off_wide[OFF_W-1:0], status: ST_OK};
				state_d    = S_DONE;
			end

			// Release.
			S_F_IDX: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = AW'(req_q.off[OFF_W-1:GRAN_SHIFT]);
				alu_req.b  = HDR_AW;
				if (in_heap) begin
					g_d       = alu_rsp.res[GW-1:0];
					mem.re    = 1'b1;
					mem.raddr = alu_rsp.res[GW-1:0];
					state_d   = S_F_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_F_CHK: begin
				hdr_d   = rdata;
				state_d = (!rdata.valid || rdata.free) ? S_DONE : S_F_NX;
			end
			S_F_NX: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(g_q);
				alu_req.b  = AW'(hdr_q.size);
				if (in_heap) begin
					nx_d      = alu_rsp.res[GW-1:0];
					mem.re    = 1'b1;
					mem.raddr = alu_rsp.res[GW-1:0];
					state_d   = S_F_NXC;
				end else begin
					state_d = S_F_PV;
				end
			end
			S_F_NXC: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(hdr_q.size);
				alu_req.b  = AW'(rdata.size);
				if (rdata.valid && rdata.free) begin
					// Absorb the following free block.
					hdr_d.size = alu_rsp.res[GW-1:0];
					mem.we     = 1'b1;
					mem.waddr  = nx_q;
					mem.wdata  = rdata;
					mem.wdata.valid = 1'b0;
					mem.wdata.free  = 1'b0;
					state_d    = S_F_NN;
				end else begin
					state_d = S_F_PV;
				end
			end
			S_F_NN: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(g_q);
				alu_req.b  = AW'(hdr_q.size);
				if (in_heap) begin
					nx_d      = alu_rsp.res[GW-1:0];
					mem.re    = 1'b1;
					mem.raddr = alu_rsp.res[GW-1:0];
					state_d   = S_F_NNW;
				end else begin
					state_d = S_F_PV;
				end
			end
			S_F_NNW: begin
				mem.we     = 1'b1;
				mem.waddr  = nx_q;
				mem.wdata  = rdata;
				mem.wdata.prev = g_q;
				state_d    = S_F_PV;
			end
			S_F_PV: begin
				if (g_q == '0) begin
					state_d = S_F_GW;
				end else begin
					mem.re    = 1'b1;
					mem.raddr = hdr_q.prev;
					state_d   = S_F_PC;
				end
			end
			S_F_PC: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(rdata.size);
				alu_req.b  = AW'(hdr_q.size);
				if (rdata.valid && rdata.free) begin
					// The previous free block absorbs this one.
					tmp_d      = alu_rsp.res[GW-1:0];
					mem.we     = 1'b1;
					mem.waddr  = hdr_q.prev;
					mem.wdata  = '{valid: 1'b1, free: 1'b1, prev: rdata.prev,
						size: alu_rsp.res[GW-1:0]};
					state_d    = S_F_PN;
				end else begin
					state_d = S_F_GW;
				end
			end
			S_F_PN: begin
				alu_req.op = ALU_ADDH;
				alu_req.a  = AW'(hdr_q.prev);
				alu_req.b  = AW'(tmp_q);
				mem.we     = 1'b1;
				mem.waddr  = g_q;
				mem.wdata  = '{valid: 1'b0, free: 1'b0, prev: hdr_q.prev,
					size: hdr_q.size};
				if (in_heap) begin
					nx_d      = alu_rsp.res[GW-1:0];
					mem.re    = 1'b1;
					mem.raddr = alu_rsp.res[GW-1:0];
					state_d   = S_F_PNW;
				end else begin
					state_d = S_DONE;
				end
			end
			S_F_PNW: begin
				mem.we     = 1'b1;
				mem.waddr  = nx_q;
				mem.wdata  = rdata;
				mem.wdata.prev = hdr_q.prev;
				state_d    = S_DONE;
			end
			S_F_GW: begin
				mem.we    = 1'b1;
				mem.waddr = g_q;
				mem.wdata = '{valid: 1'b1, free: 1'b1, prev: hdr_q.prev,
					size: hdr_q.size};
				state_d   = S_DONE;
			end

			S_DONE: begin
				done = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		g_q    <= g_d;
		need_q <= need_d;
		rem_q  <= rem_d;
		hdr_q  <= hdr_d;
		t_q    <= t_d;
		nx_q   <= nx_d;
		tmp_q  <= tmp_d;
		res_q  <= res_d;
	end

	assign res = res_q;

endmodule

[rtl/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator with coalescing.
// Instantiates ffha_seq and ffha_ram; depends on ffha_pkg.
//
// Channel   Dir  Payload                                     Handshake
// s_axis    in   tdata: request_bytes[19:0], free_offset     tvalid/tready
//                [37:20]; tuser: action[0]
// m_axis    out  tdata: user_offset[17:0]; tuser: status     tvalid/tready
//                [1:0]
//
// One request is handled at a time. An allocation rounds the size up to
// granules, walks the block headers first-fit and may split the block found;
// a release merges the block with free neighbours on either side.
// The single read port of the header RAM paces this work: every step
// of the walk is one registered read followed by one pass through the
// shared adder. After reset the S_INIT state writes the initial free
// block, then s_axis_tready rises. A result waits in the output register
// while the next request is taken; only a second finished result stalls.
module first_fit_heap_allocator_top
	import ffha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// request_bytes [19:0], free_offset [37:20], zero fill [39:38]
	input  logic [39:0] s_axis_tdata,
	// action [0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// user_offset [17:0], zero fill [23:18]
	output logic [23:0] m_axis_tdata,
	// status [1:0]
	output logic [1:0]  m_axis_tuser
);

	req_t     in_req;
	res_t     seq_res;
	mem_req_t mem;
	hdr_t     rd_hdr;
	logic     seq_idle;
	logic     seq_done;
	logic     out_free;
	logic     start;

	logic     m_valid_q;
	res_t     m_res_q;

	// Unpack the incoming request fields.
	assign in_req.action = s_axis_tuser[0];
	assign in_req.bytes  = s_axis_tdata[BYTES_W-1:0];
	assign in_req.off    = s_axis_tdata[BYTES_W+OFF_W-1:BYTES_W];

	// The sequencer takes a new request whenever it sits idle.
	assign s_axis_tready = seq_idle;
	assign start         = s_axis_tvalid & seq_idle;

	// The output slot is free when empty or being drained this cycle.
	assign out_free = !m_valid_q || m_axis_tready;

	ffha_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (in_req),
		.idle     (seq_idle),
		.out_free (out_free),
		.done     (seq_done),
		.res      (seq_res),
		.mem      (mem),
		.rdata    (rd_hdr)
	);

	ffha_ram #(
		.WIDTH (HDR_W),
		.DEPTH (HEAP_GRANULES)
	) u_hdr_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_hdr)
	);

	// Output register: holds one finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (seq_done && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done && out_free) begin
			m_res_q <= seq_res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = 24'(m_res_q.offset);
	assign m_axis_tuser  = m_res_q.status;

endmodule
